// ----- rtl/egcd_pkg.sv -----
// Package for the extended GCD block: data width, controller states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package egcd_pkg;
	localparam int DataWidth = 32;
	localparam int CntWidth = $clog2(DataWidth + 1);

	typedef logic [DataWidth-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_UPD_S,
		ST_UPD_T,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic upd_s;
		logic upd_t;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic div_done;
		logic rem_zero;
	} status_t;
endpackage
`default_nettype wire

// ----- rtl/egcd_if.sv -----
// Valid/ready channel interface for the extended GCD block.
// Depends on egcd_pkg for the word type.
`default_nettype none
interface egcd_in_if;
	logic valid;
	logic ready;
	egcd_pkg::word_t first_value;
	egcd_pkg::word_t second_value;
	modport source(output valid, first_value, second_value, input ready);
	modport sink(input valid, first_value, second_value, output ready);
endinterface

interface egcd_out_if;
	logic valid;
	logic ready;
	egcd_pkg::word_t divisor;
	egcd_pkg::word_t coeff_first;
	egcd_pkg::word_t coeff_second;
	modport source(output valid, divisor, coeff_first, coeff_second, input ready);
	modport sink(input valid, divisor, coeff_first, coeff_second, output ready);
endinterface
`default_nettype wire

// ----- rtl/egcd_datapath.sv -----
// Datapath: remainder and coefficient registers, a restoring bit-serial divider
// and one shared multiplier for the coefficient updates. Depends on egcd_pkg.
`default_nettype none
module egcd_datapath (
	input  wire logic               clk,
	input  wire egcd_pkg::cmd_t     cmd,
	input  wire egcd_pkg::word_t    in_a1,
	input  wire egcd_pkg::word_t    in_a2,
	output egcd_pkg::status_t       status,
	output egcd_pkg::word_t         res_g,
	output egcd_pkg::word_t         res_c1,
	output egcd_pkg::word_t         res_c2
);
	localparam int W = egcd_pkg::DataWidth;

	egcd_pkg::word_t r_prev_q, r_cur_q, s_prev_q, s_cur_q, t_prev_q, t_cur_q;
	egcd_pkg::word_t quo_q, rem_q, mag_q, den_q, q_signed_q, r_signed_q;
	egcd_pkg::word_t g_q, c1_q, c2_q;
	logic [egcd_pkg::CntWidth-1:0] cnt_q;
	logic special_q, q_neg_q, r_neg_q;

	egcd_pkg::word_t mag_num, mag_den, prod;
	logic [W:0] trial;
	egcd_pkg::word_t rem_shift;

	always_comb begin
		mag_num = r_prev_q[W-1] ? -r_prev_q : r_prev_q;
		mag_den = r_cur_q[W-1] ? -r_cur_q : r_cur_q;
		rem_shift = {rem_q[W-2:0], mag_q[W-1]};
		trial = {rem_q, mag_q[W-1]} - {1'b0, den_q};
		prod = q_signed_q * (cmd.upd_s ? s_cur_q : t_cur_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			special_q <= (in_a1 == '0) || (in_a2 == '0);
			g_q <= (in_a1 == '0) ? in_a2 : in_a1;
			c1_q <= (in_a1 == '0) ? '0 : ((in_a2 == '0) ? W'(1) : '0);
			c2_q <= (in_a1 == '0 && in_a2 != '0) ? W'(1) : '0;
			r_prev_q <= in_a2;
			r_cur_q <= in_a1;
			s_prev_q <= '0;
			s_cur_q <= W'(1);
			t_prev_q <= W'(1);
			t_cur_q <= '0;
		end
		if (cmd.div_init) begin
			mag_q <= mag_num;
			den_q <= mag_den;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			q_neg_q <= r_prev_q[W-1] ^ r_cur_q[W-1];
			r_neg_q <= r_prev_q[W-1];
		end
		if (cmd.div_step) begin
			// one quotient bit per cycle, restoring
			mag_q <= {mag_q[W-2:0], 1'b0};
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (status.div_done && !cmd.div_step && !cmd.div_init) begin
			q_signed_q <= q_neg_q ? -quo_q : quo_q;
			r_signed_q <= r_neg_q ? -rem_q : rem_q;
		end
		if (cmd.upd_s) begin
			s_prev_q <= s_cur_q;
			s_cur_q <= s_prev_q - prod;
		end
		if (cmd.upd_t) begin
			t_prev_q <= t_cur_q;
			t_cur_q <= t_prev_q - prod;
			r_prev_q <= r_cur_q;
			r_cur_q <= r_signed_q;
		end
		if (cmd.finish) begin
			g_q <= r_cur_q[W-1] ? -r_cur_q : r_cur_q;
			c1_q <= r_cur_q[W-1] ? -s_cur_q : s_cur_q;
			c2_q <= r_cur_q[W-1] ? -t_cur_q : t_cur_q;
		end
	end

	assign status.special = special_q;
	assign status.div_done = (cnt_q == egcd_pkg::CntWidth'(W));
	assign status.rem_zero = (r_signed_q == '0);
	assign res_g = g_q;
	assign res_c1 = c1_q;
	assign res_c2 = c2_q;
endmodule
`default_nettype wire

// ----- rtl/egcd_ctrl.sv -----
// Controller state machine for the extended GCD block: sequences load,
// division, coefficient updates and result handshake. Depends on egcd_pkg.
`default_nettype none
module egcd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire egcd_pkg::status_t  status,
	output egcd_pkg::cmd_t          cmd
);
	egcd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			egcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = egcd_pkg::ST_DIV_INIT;
				end
			end
			egcd_pkg::ST_DIV_INIT: begin
				if (status.special) begin
					state_d = egcd_pkg::ST_OUT;
				end else begin
					cmd.div_init = 1'b1;
					state_d = egcd_pkg::ST_DIV_STEP;
				end
			end
			egcd_pkg::ST_DIV_STEP: begin
				if (status.div_done) begin
					state_d = egcd_pkg::ST_UPD_S;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			egcd_pkg::ST_UPD_S: begin
				// signed quotient and remainder are registered now
				if (status.rem_zero) begin
					state_d = egcd_pkg::ST_FINISH;
				end else begin
					cmd.upd_s = 1'b1;
					state_d = egcd_pkg::ST_UPD_T;
				end
			end
			egcd_pkg::ST_UPD_T: begin
				cmd.upd_t = 1'b1;
				state_d = egcd_pkg::ST_DIV_INIT;
			end
			egcd_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = egcd_pkg::ST_OUT;
			end
			egcd_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = egcd_pkg::ST_IDLE;
				end
			end
			default: state_d = egcd_pkg::ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.div_init, cmd.div_step, cmd.upd_s, cmd.upd_t,
			cmd.finish}) <= 1)
		else $error("more than one datapath command");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_s |=> cmd.upd_t)
		else $error("coefficient update split");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("accept while result pending");
endmodule
`default_nettype wire

// ----- rtl/extended_gcd_bezout.sv -----
// Top level of the extended GCD block: joins controller and datapath.
// Depends on egcd_pkg, egcd_if, egcd_ctrl and egcd_datapath.
//
//  channel | dir | payload
//  in_ch   | in  | first_value, second_value
//  out_ch  | out | divisor, coeff_first, coeff_second
//
// Each Euclid iteration runs a setup step, the divider steps (one quotient
// bit per cycle), a step to register the signed quotient and remainder, then
// the s and t multiply-subtract updates on one shared multiplier.
// Up to ~46 iterations.
// Zero operands skip the divider and go straight to the result. One transaction is in flight at a time.
// arst_n returns the controller to idle; the result holds until taken.
`default_nettype none
module extended_gcd_bezout (
	input  wire logic clk,
	input  wire logic arst_n,
	egcd_in_if.sink   in_ch,
	egcd_out_if.source out_ch
);
	egcd_pkg::cmd_t cmd;
	egcd_pkg::status_t status;

	egcd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	egcd_datapath u_dp (
		.clk(clk),
		.cmd(cmd),
		.in_a1(in_ch.first_value),
		.in_a2(in_ch.second_value),
		.status(status),
		.res_g(out_ch.divisor),
		.res_c1(out_ch.coeff_first),
		.res_c2(out_ch.coeff_second)
	);
endmodule
`default_nettype wire

// ----- sim/extended_gcd_bezout_tb.sv -----
// Self-checking bench for extended_gcd_bezout: directed table, then random operand pairs.
// Depends on egcd_pkg, egcd_if and the RTL of the block; predicts gcd and Bezout coefficients.
`timescale 1ns / 1ps
module extended_gcd_bezout_tb;
	typedef struct packed {
		egcd_pkg::word_t divisor;
		egcd_pkg::word_t coeff_first;
		egcd_pkg::word_t coeff_second;
	} bezout_t;

	typedef struct {
		egcd_pkg::word_t a1;
		egcd_pkg::word_t a2;
		bit known;
		bezout_t res;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	egcd_in_if in_ch();
	egcd_out_if out_ch();

	bezout_t bezout_q[$];
	int mismatches = 0;
	int send_idle_pct = 23;
	int recv_idle_pct = 52;
	bit hold_off = 1'b0;
	event hold_ev;

	extended_gcd_bezout dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic egcd_pkg::word_t mag(egcd_pkg::word_t v);
		return v[egcd_pkg::DataWidth-1] ? -v : v;
	endfunction

	// truncating division on two's complement words
	function automatic void trunc_div(egcd_pkg::word_t n, egcd_pkg::word_t d,
		output egcd_pkg::word_t q, output egcd_pkg::word_t r);
		egcd_pkg::word_t uq;
		egcd_pkg::word_t ur;
		uq = mag(n) / mag(d);
		ur = mag(n) % mag(d);
		q = (n[egcd_pkg::DataWidth-1] != d[egcd_pkg::DataWidth-1]) ? -uq : uq;
		r = n[egcd_pkg::DataWidth-1] ? -ur : ur;
	endfunction

	function automatic bezout_t predict_bezout(egcd_pkg::word_t a1, egcd_pkg::word_t a2);
		egcd_pkg::word_t rp, rc, sp, sc, tp, tc, q, r, s, t;
		bezout_t b;
		if (a1 == 0 && a2 == 0) begin
			b = '{0, 0, 0};
		end else if (a1 == 0) begin
			b = '{a2, 0, 1};
		end else if (a2 == 0) begin
			b = '{a1, 1, 0};
		end else begin
			rp = a2; rc = a1; sp = 0; sc = 1; tp = 1; tc = 0;
			forever begin
				trunc_div(rp, rc, q, r);
				if (r == 0) break;
				s = sp - q * sc;
				t = tp - q * tc;
				rp = rc; rc = r; sp = sc; sc = s; tp = tc; tc = t;
			end
			if (rc[egcd_pkg::DataWidth-1]) b = '{-rc, -sc, -tc};
			else b = '{rc, sc, tc};
		end
		return b;
	endfunction

	task automatic send_pair(egcd_pkg::word_t a1, egcd_pkg::word_t a2, bezout_t exp_res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.first_value <= a1;
		in_ch.second_value <= a2;
		bezout_q.push_back(exp_res);
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic egcd_pkg::word_t rand_operand();
		egcd_pkg::word_t v;
		case ($urandom_range(5))
			0: v = $urandom_range(20);
			1: v = -egcd_pkg::word_t'($urandom_range(20));
			2: v = egcd_pkg::word_t'($urandom_range(1000))
				* egcd_pkg::word_t'($urandom_range(1, 60));
			default: v = $urandom;
		endcase
		if (v == 32'h8000_0000) v = 32'h7fff_ffff;
		return v;
	endfunction

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (bezout_q.size() != 0) @(posedge clk);
	endtask

	// count the long receiver hold-off
	initial begin
		forever begin
			@(hold_ev);
			hold_off <= 1'b1;
			repeat (6000) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_off) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		bezout_t got;
		bezout_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.divisor, out_ch.coeff_first, out_ch.coeff_second};
			if (bezout_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction %h", got);
			end else begin
				want = bezout_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp g=%h c1=%h c2=%h got g=%h c1=%h c2=%h",
							want.divisor, want.coeff_first, want.coeff_second,
							got.divisor, got.coeff_first, got.coeff_second);
				end
			end
		end
	end

	initial begin
		vec_t table_rows[$];
		egcd_pkg::word_t a1;
		egcd_pkg::word_t a2;
		table_rows = '{
			'{32'd0, 32'd0, 1, '{0, 0, 0}},
			'{32'd0, 32'd7, 1, '{7, 0, 1}},
			'{32'd0, -32'd7, 1, '{-7, 0, 1}},
			'{32'd9, 32'd0, 1, '{9, 1, 0}},
			'{-32'd9, 32'd0, 1, '{-9, 1, 0}},
			'{32'h7fff_ffff, 32'd0, 1, '{32'h7fff_ffff, 1, 0}},
			'{32'd0, 32'h8000_0001, 1, '{32'h8000_0001, 0, 1}},
			'{32'h7fff_ffff, 32'h7fff_ffff, 0, '{0, 0, 0}},
			'{32'h7fff_ffff, 32'h8000_0001, 0, '{0, 0, 0}},
			'{32'h8000_0001, 32'h8000_0001, 0, '{0, 0, 0}},
			'{32'd1, 32'd1, 0, '{0, 0, 0}},
			'{-32'd1, 32'd1, 0, '{0, 0, 0}},
			'{32'd240, 32'd46, 0, '{0, 0, 0}},
			'{-32'd240, 32'd46, 0, '{0, 0, 0}},
			'{32'd240, -32'd46, 0, '{0, 0, 0}},
			'{-32'd240, -32'd46, 0, '{0, 0, 0}},
			'{32'd1836311903, 32'd1134903170, 0, '{0, 0, 0}},
			'{32'd12, 32'd18, 0, '{0, 0, 0}},
			'{32'h5555_5555, 32'haaaa_aaab, 0, '{0, 0, 0}}
		};
		in_ch.valid = 1'b0;
		in_ch.first_value = '0;
		in_ch.second_value = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i])
			send_pair(table_rows[i].a1, table_rows[i].a2,
				table_rows[i].known ? table_rows[i].res
					: predict_bezout(table_rows[i].a1, table_rows[i].a2));
		for (int i = 0; i < 350; i++) begin
			if (i == 117) begin
				send_idle_pct = 52;
				recv_idle_pct = 23;
			end
			if (i == 234) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// hold off the receiver long enough to stall the input side
			if (i == 60 || i == 260) -> hold_ev;
			// pause the sender until everything is back
			if (i == 150 || i == 300) wait_drained();
			a1 = rand_operand();
			a2 = rand_operand();
			send_pair(a1, a2, predict_bezout(a1, a2));
		end
		wait_drained();
		repeat (2000) @(posedge clk);
		if (mismatches == 0 && bezout_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/egcd_pkg.sv
rtl/egcd_if.sv
rtl/egcd_datapath.sv
rtl/egcd_ctrl.sv
rtl/extended_gcd_bezout.sv
sim/extended_gcd_bezout_tb.sv
